// File: design/atilt_pkg.sv
// Package with constants, controller states, command/status types and the arctangent table.
package atilt_pkg;

    localparam int FRAME_BYTES  = 6;
    localparam int STORE_DEPTH  = FRAME_BYTES - 1;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 24;
    localparam int C_W          = 28;
    localparam int ACC_W        = 34;
    localparam int Q_W          = ACC_W - 17;

    localparam logic [2:0] LAST_DATA_IDX = 3'(STORE_DEPTH);
    localparam logic [4:0] CORDIC_LAST   = 5'(CORDIC_STEPS - 1);
    localparam logic [4:0] SQRT_LAST     = 5'(SQRT_STEPS - 1);

    localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Q_W-1:0]   PI_Q13      = 17'sd25736;
    localparam logic signed [Q_W-1:0]   HALF_PI_Q13 = 17'sd12868;
    localparam logic [7:0]              SYNC_RESET  = 8'hFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MULX,
        S_MULZ,
        S_SQINIT,
        S_SQRT,
        S_RINIT,
        S_RRUN,
        S_PINIT,
        S_PRUN,
        S_PSAVE
    } t_state;

    typedef struct packed {
        logic       store_we;
        logic [2:0] store_idx;
        logic       zhi_we;
        logic       mul_x;
        logic       mul_z;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       cordic_init;
        logic       cordic_pitch;
        logic       cordic_step;
        logic       roll_save;
        logic       pitch_save;
    } t_cmd;

    typedef struct packed {
        logic sqrt_last;
        logic cordic_last;
    } t_status;

    function automatic logic signed [ACC_W-1:0] f_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return $signed({2'b00, v});
    endfunction

endpackage

// File: design/atilt_ctrl.sv
// Controller: frame parser, sync register, sequencing state machine and output valid.
module atilt_ctrl import atilt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_sync_value,
    output t_cmd       o_cmd,
    input  t_status    i_status
);

    t_state     r_state, n_state;
    logic       r_in_frame, n_in_frame;
    logic [2:0] r_count, n_count;
    logic [7:0] r_sync;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_stall     = (r_state != S_IDLE) ||
                         (r_out_valid && r_in_frame && r_count == LAST_DATA_IDX);
    assign accept      = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_frame  <= 1'b0;
            r_count     <= '0;
            r_sync      <= SYNC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_frame  <= n_in_frame;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_sync <= i_sync_value;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_in_frame  = r_in_frame;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        o_cmd.store_idx = r_count;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!r_in_frame) begin
                        if (i_rx_byte == r_sync) begin
                            n_in_frame = 1'b1;
                            n_count    = '0;
                        end
                    end else if (r_count < LAST_DATA_IDX) begin
                        o_cmd.store_we = 1'b1;
                        n_count        = r_count + 3'd1;
                    end else begin
                        o_cmd.zhi_we = 1'b1;
                        n_in_frame   = 1'b0;
                        n_count      = '0;
                        n_state      = S_MULX;
                    end
                end
            end
            S_MULX: begin
                o_cmd.mul_x = 1'b1;
                n_state     = S_MULZ;
            end
            S_MULZ: begin
                o_cmd.mul_z = 1'b1;
                n_state     = S_SQINIT;
            end
            S_SQINIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.sqrt_last) begin
                    n_state = S_RINIT;
                end
            end
            S_RINIT: begin
                o_cmd.cordic_init = 1'b1;
                n_state           = S_RRUN;
            end
            S_RRUN: begin
                o_cmd.cordic_step = 1'b1;
                if (i_status.cordic_last) begin
                    n_state = S_PINIT;
                end
            end
            S_PINIT: begin
                o_cmd.roll_save    = 1'b1;
                o_cmd.cordic_init  = 1'b1;
                o_cmd.cordic_pitch = 1'b1;
                n_state            = S_PRUN;
            end
            S_PRUN: begin
                o_cmd.cordic_step = 1'b1;
                if (i_status.cordic_last) begin
                    n_state = S_PSAVE;
                end
            end
            S_PSAVE: begin
                o_cmd.pitch_save = 1'b1;
                n_out_valid      = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/atilt_dp.sv
// Datapath: frame bytes, squaring, bit-serial square root, shared CORDIC and result registers.
module atilt_dp import atilt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_rx_byte,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    output logic signed [15:0]  o_roll_angle,
    output logic signed [14:0]  o_pitch_angle,
    output logic signed [15:0]  o_accel_x,
    output logic signed [15:0]  o_accel_y,
    output logic signed [15:0]  o_accel_z
);

    logic [7:0]               r_store [STORE_DEPTH];
    logic [7:0]               r_zhi;
    logic [32:0]              r_sq;
    logic [47:0]              r_rad;
    logic [27:0]              r_rem;
    logic [23:0]              r_root;
    logic [4:0]               r_sq_cnt;
    logic signed [C_W-1:0]    r_cx, r_cy;
    logic signed [ACC_W-1:0]  r_acc;
    logic [4:0]               r_step;
    logic                     r_zero, r_negpi;
    logic signed [Q_W-1:0]    r_lim;
    logic signed [15:0]       r_roll, r_ax, r_ay, r_az;
    logic signed [14:0]       r_pitch;

    logic signed [15:0]       ax, ay, az;
    logic signed [31:0]       prod;
    logic signed [15:0]       mul_in;
    logic [27:0]              rem_sh, trial;
    logic signed [C_W-1:0]    y0, x0, xs, ys;
    logic signed [Q_W-1:0]    q, qc, res;

    assign ax = $signed({r_store[1], r_store[0]});
    assign ay = $signed({r_store[3], r_store[2]});
    assign az = $signed({r_zhi, r_store[4]});

    assign mul_in = i_cmd.mul_x ? ax : az;
    assign prod   = mul_in * mul_in;

    assign rem_sh = {r_rem[25:0], r_rad[47:46]};
    assign trial  = {2'b00, r_root, 2'b01};

    assign y0 = i_cmd.cordic_pitch ? -$signed({{4{ay[15]}}, ay, 8'h00})
                                   : $signed({{4{ax[15]}}, ax, 8'h00});
    assign x0 = i_cmd.cordic_pitch ? $signed({4'h0, r_root})
                                   : $signed({{4{az[15]}}, az, 8'h00});
    assign xs = r_cx >>> r_step;
    assign ys = r_cy >>> r_step;

    assign q   = Q_W'((r_acc + ACC_W'(65536)) >>> 17);
    assign qc  = (q > r_lim) ? r_lim : ((q < -r_lim) ? -r_lim : q);
    assign res = r_zero ? '0 : (r_negpi ? r_lim : qc);

    assign o_status.sqrt_last   = (r_sq_cnt == SQRT_LAST);
    assign o_status.cordic_last = (r_step == CORDIC_LAST);

    assign o_roll_angle  = r_roll;
    assign o_pitch_angle = r_pitch;
    assign o_accel_x     = r_ax;
    assign o_accel_y     = r_ay;
    assign o_accel_z     = r_az;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_we) begin
            r_store[i_cmd.store_idx] <= i_rx_byte;
        end
        if (i_cmd.zhi_we) begin
            r_zhi <= i_rx_byte;
        end
        if (i_cmd.mul_x) begin
            r_sq <= {1'b0, prod};
        end
        if (i_cmd.mul_z) begin
            r_sq <= r_sq + {1'b0, prod};
        end
        if (i_cmd.sqrt_init) begin
            r_rad <= {r_sq[31:0], 16'h0000};
            r_rem <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[45:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[22:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[22:0], 1'b0};
            end
        end
        if (i_cmd.cordic_init) begin
            r_zero  <= (y0 == 0) && (x0 == 0);
            r_negpi <= (y0 == 0) && (x0 < 0);
            r_lim   <= i_cmd.cordic_pitch ? HALF_PI_Q13 : PI_Q13;
            if (x0 < 0) begin
                if (y0 >= 0) begin
                    r_cx  <= y0;
                    r_cy  <= -x0;
                    r_acc <= HALF_PI_Q30;
                end else begin
                    r_cx  <= -y0;
                    r_cy  <= x0;
                    r_acc <= -HALF_PI_Q30;
                end
            end else begin
                r_cx  <= x0;
                r_cy  <= y0;
                r_acc <= '0;
            end
        end
        if (i_cmd.cordic_step) begin
            if (r_cy > 0) begin
                r_cx  <= r_cx + ys;
                r_cy  <= r_cy - xs;
                r_acc <= r_acc + f_atan(r_step);
            end else begin
                r_cx  <= r_cx - ys;
                r_cy  <= r_cy + xs;
                r_acc <= r_acc - f_atan(r_step);
            end
        end
        if (i_cmd.roll_save) begin
            r_roll <= res[15:0];
        end
        if (i_cmd.pitch_save) begin
            r_pitch <= res[14:0];
            r_ax    <= ax;
            r_ay    <= ay;
            r_az    <= az;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_cnt <= '0;
            r_step   <= '0;
        end else begin
            if (i_cmd.sqrt_init) begin
                r_sq_cnt <= '0;
            end else if (i_cmd.sqrt_step) begin
                r_sq_cnt <= r_sq_cnt + 5'd1;
            end
            if (i_cmd.cordic_init) begin
                r_step <= '0;
            end else if (i_cmd.cordic_step) begin
                r_step <= r_step + 5'd1;
            end
        end
    end

endmodule

// File: design/accel_frame_tilt_angles_core.sv
// Top level: byte-stream accelerometer frame parser with roll and pitch angles.
// Data bytes are taken one per cycle while o_stall is low; the sixth data byte starts a
// computation of squaring, square root (one result bit per cycle), a roll CORDIC pass,
// a pitch CORDIC pass and a save step that registers pitch, the raw axes and output valid.
// Input is stalled during the computation, so no new frame byte is taken until it ends.
// Synchronous active-low reset clears the parser, the state machine and output valid.
module accel_frame_tilt_angles_core import atilt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_roll_angle,
    output logic signed [14:0] o_pitch_angle,
    output logic signed [15:0] o_accel_x,
    output logic signed [15:0] o_accel_y,
    output logic signed [15:0] o_accel_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_sync_value
);

    t_cmd    cmd;
    t_status status;

    atilt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_rx_byte    (i_rx_byte),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_sync_value (i_sync_value),
        .o_cmd        (cmd),
        .i_status     (status)
    );

    atilt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_byte     (i_rx_byte),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_roll_angle  (o_roll_angle),
        .o_pitch_angle (o_pitch_angle),
        .o_accel_x     (o_accel_x),
        .o_accel_y     (o_accel_y),
        .o_accel_z     (o_accel_z)
    );

endmodule
